/* sv/wsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the WebSocket frame deframer
// Holds the queue item passed from the header parser to the unmask stage and
// the fixed codes of the base framing header.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Field widths fixed by the framing format
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OPC_W  = 4;
  localparam int unsigned LEN_W  = 63;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned LANE_W = 2;
  localparam int unsigned CNT_W  = 3;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Header byte counter value on the last byte of each header section
  localparam logic [CNT_W-1:0] EXT16_LAST_CNT = 3'd1;
  localparam logic [CNT_W-1:0] EXT64_LAST_CNT = 3'd7;
  localparam logic [CNT_W-1:0] KEY_LAST_CNT   = 3'd3;

  // Masking key lane selects, key byte 0 is the first key byte received
  localparam logic [LANE_W-1:0] LANE_0 = 2'd0;
  localparam logic [LANE_W-1:0] LANE_1 = 2'd1;
  localparam logic [LANE_W-1:0] LANE_2 = 2'd2;
  localparam logic [LANE_W-1:0] LANE_3 = 2'd3;

  // Classified beat handed from the parser to the unmask stage
  typedef struct packed {
    logic              fin;
    logic [OPC_W-1:0]  opcode;
    logic              masked;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data;
    logic [KEY_W-1:0]  key;
    logic [LANE_W-1:0] lane;
    logic              byte_valid;
    logic              last;
  } wsd_item_t;

endpackage

/* sv/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket base framing parser
// Splits a byte stream of back-to-back frames into header fields and
// unmasked payload bytes, one result beat per payload byte or empty frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   data_byte (8)
//  out_     output     out_valid / out_stall fin, opcode, mask, length, byte,
//                                            byte_valid, last
//
//  One byte accepted per cycle while in_stall is low; header bytes give no
//  result, each payload byte gives one, an empty frame gives one marker beat
//  with byte_valid low. A byte's result passes the queue, then the output register.
//  Input stalls only once the QUEUE_DEPTH-entry queue is full.
//  Synchronous active-low reset; no clearing pass, ready the cycle after.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wsd_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_fin_bit,
  output logic [wsd_pkg::OPC_W-1:0]   out_frame_opcode,
  output logic                        out_was_masked,
  output logic [wsd_pkg::LEN_W-1:0]   out_frame_length,
  output logic [wsd_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic                        out_byte_valid,
  output logic                        out_frame_last
);
  import wsd_pkg::*;

  logic       push;
  logic       push_ready;
  wsd_item_t  push_item;
  logic       pop;
  logic       head_valid;
  wsd_item_t  head_item;

  // Header parser
  wsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .push         (push),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  // Decoupling queue
  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Unmask and output stage
  wsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fin_bit      (out_fin_bit),
    .out_frame_opcode (out_frame_opcode),
    .out_was_masked   (out_was_masked),
    .out_frame_length (out_frame_length),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_last   (out_frame_last)
  );

`ifndef SYNTHESIS
  // Empty-frame beat is the only beat of a zero-length frame
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_frame_last && out_frame_length == '0)
    else $error("empty-frame beat without last or with nonzero length");

  a_empty_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_payload_byte == '0)
    else $error("empty-frame beat carries a nonzero byte");

  a_data_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_frame_length != '0)
    else $error("payload byte emitted for a zero-length frame");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

/* sv/wsd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front: frame header parser
// Walks the header of each frame one byte per beat, gathers FIN, opcode,
// mask flag, length and masking key, and pushes one item per payload byte
// (or one empty-frame item) into the queue.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [wsd_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                          in_stall,
  output logic                          push,
  output wsd_pkg::wsd_item_t            push_item,
  input  logic                          push_ready
);
  import wsd_pkg::*;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } wsd_phase_t;

  wsd_phase_t          state_r, state_nxt;
  logic                fin_r, fin_nxt;
  logic [OPC_W-1:0]    opcode_r, opcode_nxt;
  logic                masked_r, masked_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    remain_r, remain_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ext_long_r, ext_long_nxt;
  logic [LANE_W-1:0]   lane_r, lane_nxt;

  logic                accept;
  logic                hdr_done;
  logic                start_pl;
  logic                item_valid;
  logic                item_last;
  logic [6:0]          len_code;

  assign accept   = in_valid && push_ready;
  assign in_stall = !push_ready;
  assign len_code = in_data_byte[6:0];

  // Next-state logic of the header walk
  always_comb begin
    state_nxt    = state_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    len_nxt      = len_r;
    remain_nxt   = remain_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    ext_long_nxt = ext_long_r;
    lane_nxt     = lane_r;
    hdr_done     = 1'b0;
    start_pl     = 1'b0;
    push         = 1'b0;
    item_valid   = 1'b0;
    item_last    = 1'b0;

    if (accept) begin
      case (state_r)
        PH_FIRST: begin
          // RSV bits are ignored
          fin_nxt    = in_data_byte[7];
          opcode_nxt = in_data_byte[OPC_W-1:0];
          state_nxt  = PH_LENGTH;
        end
        PH_LENGTH: begin
          masked_nxt = in_data_byte[7];
          cnt_nxt    = '0;
          if (len_code == LEN_CODE_EXT16) begin
            ext_long_nxt = 1'b0;
            len_nxt      = '0;
            state_nxt    = PH_EXTLEN;
          end else if (len_code == LEN_CODE_EXT64) begin
            ext_long_nxt = 1'b1;
            len_nxt      = '0;
            state_nxt    = PH_EXTLEN;
          end else begin
            len_nxt  = LEN_W'(len_code);
            hdr_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // Big-endian shift-in; bit 63 of a long length falls off the top
          len_nxt = {len_r[LEN_W-BYTE_W-1:0], in_data_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == (ext_long_r ? EXT64_LAST_CNT : EXT16_LAST_CNT)) begin
            cnt_nxt  = '0;
            hdr_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[KEY_W-BYTE_W-1:0], in_data_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == KEY_LAST_CNT) begin
            cnt_nxt  = '0;
            start_pl = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push       = 1'b1;
          item_valid = 1'b1;
          item_last  = (remain_r == LEN_W'(1));
          remain_nxt = remain_r - LEN_W'(1);
          lane_nxt   = lane_r + 2'd1;
          if (item_last) begin
            state_nxt = PH_FIRST;
            lane_nxt  = LANE_0;
          end
        end
        default: begin
          state_nxt = PH_FIRST;
        end
      endcase

      // Length known: fetch the key or go straight to payload
      if (hdr_done) begin
        if (masked_nxt) begin
          state_nxt = PH_KEY;
        end else begin
          start_pl = 1'b1;
        end
      end

      // Header complete: an empty frame yields one marker beat
      if (start_pl) begin
        lane_nxt   = LANE_0;
        remain_nxt = len_nxt;
        if (len_nxt == '0) begin
          state_nxt = PH_FIRST;
          push      = 1'b1;
          item_last = 1'b1;
        end else begin
          state_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  // Queue item
  always_comb begin
    push_item            = '0;
    push_item.fin        = fin_nxt;
    push_item.opcode     = opcode_nxt;
    push_item.masked     = masked_nxt;
    push_item.length     = len_nxt;
    push_item.data       = item_valid ? in_data_byte : '0;
    push_item.key        = key_r;
    push_item.lane       = lane_r;
    push_item.byte_valid = item_valid;
    push_item.last       = item_last;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= PH_FIRST;
      cnt_r      <= '0;
      ext_long_r <= 1'b0;
      lane_r     <= LANE_0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ext_long_r <= ext_long_nxt;
      lane_r     <= lane_nxt;
    end
  end

  // Held header fields
  always_ff @(posedge clk) begin
    fin_r    <= fin_nxt;
    opcode_r <= opcode_nxt;
    masked_r <= masked_nxt;
    len_r    <= len_nxt;
    remain_r <= remain_nxt;
    key_r    <= key_nxt;
  end

endmodule

/* sv/wsd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_queue: short item queue between parser and unmask stage
// Register-based FIFO; lets the parser keep taking bytes while the output
// side is stalled, up to DEPTH items.
// ----------------------------------------------------------------------------
module wsd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wsd_pkg::wsd_item_t   push_item,
  output logic                 push_ready,
  input  logic                 pop,
  output logic                 head_valid,
  output wsd_pkg::wsd_item_t   head_item
);
  import wsd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(DEPTH + 1);

  wsd_item_t           slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != QCNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/wsd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back: unmask stage and output register
// Pops queue items, XORs payload bytes with the selected masking key byte
// and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  wsd_pkg::wsd_item_t          head_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_fin_bit,
  output logic [wsd_pkg::OPC_W-1:0]   out_frame_opcode,
  output logic                        out_was_masked,
  output logic [wsd_pkg::LEN_W-1:0]   out_frame_length,
  output logic [wsd_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic                        out_byte_valid,
  output logic                        out_frame_last
);
  import wsd_pkg::*;

  logic                valid_r;
  logic                fin_r;
  logic [OPC_W-1:0]    opcode_r;
  logic                masked_r;
  logic [LEN_W-1:0]    len_r;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                bvalid_r;
  logic                last_r;
  logic [BYTE_W-1:0]   key_byte;

  // Output register is free when empty or being taken
  assign pop = head_valid && (!valid_r || !out_stall);

  // Key byte for this payload position
  always_comb begin
    case (head_item.lane)
      LANE_0:  key_byte = head_item.key[31:24];
      LANE_1:  key_byte = head_item.key[23:16];
      LANE_2:  key_byte = head_item.key[15:8];
      LANE_3:  key_byte = head_item.key[7:0];
      default: key_byte = '0;
    endcase
  end

  // Unmask; empty-frame beats carry a zero byte
  always_comb begin
    byte_nxt = head_item.data;
    if (head_item.masked && head_item.byte_valid) begin
      byte_nxt = head_item.data ^ key_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fin_r    <= head_item.fin;
      opcode_r <= head_item.opcode;
      masked_r <= head_item.masked;
      len_r    <= head_item.length;
      byte_r   <= byte_nxt;
      bvalid_r <= head_item.byte_valid;
      last_r   <= head_item.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_fin_bit      = fin_r;
  assign out_frame_opcode = opcode_r;
  assign out_was_masked   = masked_r;
  assign out_frame_length = len_r;
  assign out_payload_byte = byte_r;
  assign out_byte_valid   = bvalid_r;
  assign out_frame_last   = last_r;

endmodule

/* verif/wsd_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_frame_checker: scoreboard for the WebSocket frame deframer
// Watches the byte channel and the result channel. Every accepted input byte
// goes through a local frame parser. Each payload byte, and each empty-frame
// marker, is queued as an expected beat. Result beats are compared field by
// field against the oldest expected beat.
// ----------------------------------------------------------------------------
module wsd_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [wsd_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_fin_bit,
  input  logic [wsd_pkg::OPC_W-1:0]   out_frame_opcode,
  input  logic                        out_was_masked,
  input  logic [wsd_pkg::LEN_W-1:0]   out_frame_length,
  input  logic [wsd_pkg::BYTE_W-1:0]  out_payload_byte,
  input  logic                        out_byte_valid,
  input  logic                        out_frame_last,
  output int unsigned                 mismatches,
  output int unsigned                 beats_waiting
);
  import wsd_pkg::*;

  typedef enum logic [4:0] {
    HDR_FIRST = 5'b00001,
    HDR_LEN   = 5'b00010,
    HDR_EXT   = 5'b00100,
    HDR_KEY   = 5'b01000,
    HDR_DATA  = 5'b10000
  } parse_state_t;

  typedef struct packed {
    logic              fin;
    logic [OPC_W-1:0]  opcode;
    logic              masked;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] pbyte;
    logic              bvalid;
    logic              last;
  } deframed_beat_t;

  // Local parser state
  parse_state_t     pstate;
  logic             f_fin;
  logic [OPC_W-1:0] f_opcode;
  logic             f_masked;
  logic [63:0]      f_length;
  logic [CNT_W-1:0] hdr_cnt;
  logic [CNT_W-1:0] ext_last_cnt;
  logic [KEY_W-1:0] f_key;
  logic [63:0]      pay_idx;

  deframed_beat_t expected_beats[$];
  int unsigned    errs;

  function automatic deframed_beat_t frame_beat(logic [BYTE_W-1:0] pb, logic bv, logic lst);
    deframed_beat_t bt;
    bt.fin    = f_fin;
    bt.opcode = f_opcode;
    bt.masked = f_masked;
    bt.length = f_length[LEN_W-1:0];
    bt.pbyte  = pb;
    bt.bvalid = bv;
    bt.last   = lst;
    return bt;
  endfunction

  // Header finished: an empty frame gives its marker beat at once
  task automatic open_payload();
    pay_idx = '0;
    if (f_length == 64'd0) begin
      pstate = HDR_FIRST;
      expected_beats.push_back(frame_beat('0, 1'b0, 1'b1));
    end else begin
      pstate = HDR_DATA;
    end
  endtask

  // Length known; top bit of a 64-bit length is dropped
  task automatic length_known();
    f_length[63] = 1'b0;
    hdr_cnt = '0;
    if (f_masked) begin
      pstate = HDR_KEY;
    end else begin
      open_payload();
    end
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] kb;
    logic              lst;
    case (pstate)
      HDR_FIRST: begin
        // RSV bits are ignored
        f_fin    = b[7];
        f_opcode = b[OPC_W-1:0];
        pstate   = HDR_LEN;
      end
      HDR_LEN: begin
        f_masked = b[7];
        hdr_cnt  = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          ext_last_cnt = EXT16_LAST_CNT;
          f_length     = '0;
          pstate       = HDR_EXT;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          ext_last_cnt = EXT64_LAST_CNT;
          f_length     = '0;
          pstate       = HDR_EXT;
        end else begin
          f_length = {57'd0, b[6:0]};
          length_known();
        end
      end
      HDR_EXT: begin
        // big-endian extended length
        f_length = {f_length[55:0], b};
        if (hdr_cnt == ext_last_cnt) begin
          length_known();
        end else begin
          hdr_cnt++;
        end
      end
      HDR_KEY: begin
        f_key = {f_key[KEY_W-9:0], b};
        if (hdr_cnt == KEY_LAST_CNT) begin
          hdr_cnt = '0;
          open_payload();
        end else begin
          hdr_cnt++;
        end
      end
      default: begin
        // first key byte sits in the top lane; unmasked frames ignore a stale key
        kb  = f_key[8 * (3 - pay_idx[1:0]) + 7 -: 8];
        lst = (pay_idx + 64'd1 >= f_length);
        expected_beats.push_back(frame_beat(f_masked ? (b ^ kb) : b, 1'b1, lst));
        if (lst) begin
          pstate  = HDR_FIRST;
          pay_idx = '0;
        end else begin
          pay_idx++;
        end
      end
    endcase
  endtask

  function automatic void check_field(string fld, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      errs++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want_v, got_v);
    end
  endfunction

  // Result beats are checked before the input byte of the same edge is parsed
  always @(posedge clk) begin
    deframed_beat_t got;
    deframed_beat_t want;
    if (!rst_n) begin
      pstate       = HDR_FIRST;
      f_fin        = 1'b0;
      f_opcode     = '0;
      f_masked     = 1'b0;
      f_length     = '0;
      hdr_cnt      = '0;
      ext_last_cnt = '0;
      f_key        = '0;
      pay_idx      = '0;
      errs         = 0;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_fin_bit, out_frame_opcode, out_was_masked, out_frame_length,
               out_payload_byte, out_byte_valid, out_frame_last};
        if (expected_beats.size() == 0) begin
          errs++;
          $display("%0t ns: unexpected result beat, expected none, actual 0x%0h", $time, got);
        end else begin
          want = expected_beats.pop_front();
          check_field("fin_bit", want.fin, got.fin);
          check_field("frame_opcode", want.opcode, got.opcode);
          check_field("was_masked", want.masked, got.masked);
          check_field("frame_length", want.length, got.length);
          check_field("payload_byte", want.pbyte, got.pbyte);
          check_field("byte_valid", want.bvalid, got.bvalid);
          check_field("frame_last", want.last, got.last);
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte);
      end
    end
    mismatches    <= errs;
    beats_waiting <= expected_beats.size();
  end

endmodule

/* verif/websocket_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb: top-level testbench of the frame deframer
// Feeds streams of back-to-back frames: a few hand-built frames for empty,
// extended-length and masking corner cases, a long receiver hold-off to back
// the block up, random frames, and a huge 64-bit-length frame at the end.
// Both channels idle at random; the checker predicts and compares beats.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum int unsigned {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  typedef enum int unsigned {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_fin_bit;
  logic [OPC_W-1:0]  out_frame_opcode;
  logic              out_was_masked;
  logic [LEN_W-1:0]  out_frame_length;
  logic [BYTE_W-1:0] out_payload_byte;
  logic              out_byte_valid;
  logic              out_frame_last;

  int unsigned mismatches;
  int unsigned beats_waiting;

  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned frame_no;
  bit          no_gaps;
  bit          rx_hold_go;

  websocket_frame_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fin_bit     (out_fin_bit),
    .out_frame_opcode(out_frame_opcode),
    .out_was_masked  (out_was_masked),
    .out_frame_length(out_frame_length),
    .out_payload_byte(out_payload_byte),
    .out_byte_valid  (out_byte_valid),
    .out_frame_last  (out_frame_last)
  );

  wsd_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fin_bit     (out_fin_bit),
    .out_frame_opcode(out_frame_opcode),
    .out_was_masked  (out_was_masked),
    .out_frame_length(out_frame_length),
    .out_payload_byte(out_payload_byte),
    .out_byte_valid  (out_byte_valid),
    .out_frame_last  (out_frame_last),
    .mismatches      (mismatches),
    .beats_waiting   (beats_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: stall pattern switches mode now and then; long hold on request
  initial begin
    rx_mode_t    rx_mode;
    int unsigned mode_left;
    int unsigned phase;
    int unsigned period;
    rx_mode   = RX_FREE;
    mode_left = 0;
    phase     = 0;
    period    = 4;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
        period    = $urandom_range(2, 7);
      end
      mode_left--;
      phase++;
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        RX_PERIODIC: out_stall <= ((phase % period) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // One input beat; bursts of random length with random gaps after them
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 16);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Header, optional key, then n_bytes random payload bytes
  task automatic send_frame(input logic [BYTE_W-1:0] hdr0, input logic masked,
                            input len_form_t form, input logic [63:0] len_val,
                            input logic [KEY_W-1:0] key, input int unsigned n_bytes);
    push_byte(hdr0);
    case (form)
      LEN_SHORT: push_byte({masked, len_val[6:0]});
      LEN_EXT16: begin
        push_byte({masked, LEN_CODE_EXT16});
        push_byte(len_val[15:8]);
        push_byte(len_val[7:0]);
      end
      default: begin
        push_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len_val[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
    end
    repeat (n_bytes) push_byte(8'($urandom_range(0, 255)));
    frame_no++;
  endtask

  // Mostly short frames; opcode walks through all codes, RSV and FIN random
  task automatic random_frame();
    logic [63:0]  len_val;
    len_form_t    form;
    int unsigned  pick;
    int unsigned  n;
    pick    = $urandom_range(0, 9);
    len_val = '0;
    if (pick < 6) begin
      form = LEN_SHORT;
      case ($urandom_range(0, 9))
        0:       len_val[6:0] = 7'd125;
        1:       len_val[6:0] = 7'($urandom_range(0, 125));
        default: len_val[6:0] = 7'($urandom_range(0, 16));
      endcase
      n = 32'(len_val[6:0]);
    end else if (pick < 9) begin
      form = LEN_EXT16;
      len_val[15:0] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 400))
                                                  : 16'($urandom_range(0, 24));
      n = 32'(len_val[15:0]);
    end else begin
      form = LEN_EXT64;
      len_val[62:0] = 63'($urandom_range(0, 24));
      len_val[63]   = 1'($urandom_range(0, 1));
      n = 32'(len_val[15:0]);
    end
    send_frame({4'($urandom_range(0, 15)), 4'(frame_no)}, 1'($urandom_range(0, 1)),
               form, len_val, $urandom, n);
  endtask

  // Sender idles until every expected beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_waiting != 0) @(posedge clk);
  endtask

  initial begin
    bytes_sent   = 0;
    burst_left   = 0;
    frame_no     = 0;
    no_gaps      = 1'b0;
    rx_hold_go   = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty frames: plain, masked, 16-bit zero, 64-bit zero with top bit set
    send_frame(8'h80, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
    send_frame(8'h7F, 1'b1, LEN_SHORT, 64'd0, 32'hA5C3_0F96, 0);
    send_frame(8'h8A, 1'b0, LEN_EXT16, 64'd0, 32'h0, 0);
    send_frame(8'h02, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0000, 32'h1234_5678, 0);
    // All-ones key inverts; the next unmasked frame must ignore the old key
    send_frame(8'h81, 1'b1, LEN_SHORT, 64'd5, 32'hFFFF_FFFF, 5);
    send_frame(8'h82, 1'b0, LEN_EXT16, 64'd3, 32'h0, 3);
    // 64-bit length with the reserved top bit set
    send_frame(8'h01, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0002, 32'h0102_0408, 2);
    drain_results();

    // Receiver holds off while bytes keep coming, so the input backs up
    no_gaps    = 1'b1;
    rx_hold_go = 1'b1;
    send_frame(8'h82, 1'b1, LEN_SHORT, 64'd60, $urandom, 60);
    no_gaps = 1'b0;
    drain_results();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      random_frame();
      if ((frame_no % 25) == 0) drain_results();
    end
    drain_results();

    // Largest length: frame never finishes, every beat carries the 63-bit length
    send_frame(8'h82, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 24);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && beats_waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
